>>> sv/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg - shared types and constants for the differential drive mixer
// Holds fixed-point constants, divider port structs and small helpers.
// ----------------------------------------------------------------------------
package ddm_pkg;

	// fixed-point constants (Q1.15 and Q16)
	localparam logic [4:0]  TRIM_MAX   = 5'd20;
	localparam logic [16:0] DEADBAND   = 17'd410;
	localparam logic [17:0] TRIM_SPEED = 18'd29491;
	localparam logic [16:0] LN2_Q16    = 17'd45426;
	localparam logic [16:0] HALF_Q15   = 17'd16384;
	localparam logic [20:0] ONE_Q15    = 21'd32768;

	// reciprocal of 5 in Q21, exact floor for dividends below 2^19
	localparam logic [19:0] RCP_DIV5   = 20'd419431;

	// divider geometry
	localparam int DVD_W = 36;
	localparam int DSR_W = 21;
	localparam int QUO_W = 16;

	// configuration register indexes
	localparam logic [2:0] REG_LEFT_INV  = 3'd0;
	localparam logic [2:0] REG_RIGHT_INV = 3'd1;
	localparam logic [2:0] REG_FWD_INV   = 3'd2;
	localparam logic [2:0] REG_TURN_INV  = 3'd3;
	localparam logic [2:0] REG_TURBO_G   = 3'd4;
	localparam logic [2:0] REG_NORMAL_G  = 3'd5;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

	// magnitude of a 16-bit signed value
	function automatic logic [16:0] abs16(input logic [15:0] v);
		logic [16:0] e;
		begin
			e = {v[15], v};
			abs16 = v[15] ? 17'(~e + 17'd1) : e;
		end
	endfunction

endpackage

>>> sv/ddm_div.sv
// ----------------------------------------------------------------------------
// ddm_div - restoring divider, one quotient bit per cycle
// Quotient must fit in QUO_W bits; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module ddm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ddm_pkg::div_req_t req,
	output ddm_pkg::div_rsp_t rsp
);
	import ddm_pkg::*;

	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [QUO_W-1:0] sh_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   rem2;
	logic             ge;

	// trial subtract of the next partial remainder
	always_comb begin
		rem2 = {rem_q, sh_q[QUO_W-1]};
		ge   = rem2 >= {1'b0, dsr_q};
	end

	// sequencing and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd15);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15)
					busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DSR_W'(req.dividend[DVD_W-1:QUO_W]);
			sh_q  <= req.dividend[QUO_W-1:0];
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DSR_W'(rem2 - {1'b0, dsr_q}) : rem2[DSR_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

>>> sv/differential_drive_mixer_with_trim.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_with_trim - tank / arcade drive mixer in Q1.15
// One shared multiplier and one serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// timing: a result reaches m_tvalid once the item's state sequence is done, plus any
//   wait in ST_OUT for the previous result to leave
// throughput: one item at a time, the next transfer is taken in ST_IDLE once the
//   result is registered; a nonzero arcade turn costs 16 log squarings and a divide
// reset: trims and press latch cleared, gains 1.0 / 0.5, inverts off
module differential_drive_mixer_with_trim (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// stick_a, stick_b, trigger_axis, turbo_held, trim_right_req,
	// trim_left_req, trim_clear_req, slow_turn_held, zero pad
	input  logic [55:0] s_tdata,
	// func
	input  logic        s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_drive, right_drive, left_trim_count, right_trim_count, zero pad
	output logic [47:0] m_tdata
);
	import ddm_pkg::*;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_T_MUL   = 5'd1;
	localparam logic [4:0] ST_T_CHK   = 5'd2;
	localparam logic [4:0] ST_TR_MUL  = 5'd3;
	localparam logic [4:0] ST_TR_WAIT = 5'd4;
	localparam logic [4:0] ST_STORE   = 5'd5;
	localparam logic [4:0] ST_A_FWD   = 5'd6;
	localparam logic [4:0] ST_A_NORM  = 5'd7;
	localparam logic [4:0] ST_A_SQ    = 5'd8;
	localparam logic [4:0] ST_A_LN    = 5'd9;
	localparam logic [4:0] ST_A_DIV   = 5'd10;
	localparam logic [4:0] ST_A_DWT   = 5'd11;
	localparam logic [4:0] ST_A_MIX   = 5'd12;
	localparam logic [4:0] ST_A_TCHK  = 5'd13;
	localparam logic [4:0] ST_OUT     = 5'd14;

	logic [4:0]  state_q;

	// configuration registers
	logic        lti_q, rti_q, fwi_q, tni_q;
	logic [15:0] turbo_g_q, normal_g_q;

	// trim state
	logic [4:0]  lsteps_q, rsteps_q;
	logic        latch_q;

	// captured item
	logic        func_q, turbo_q, slow_q;
	logic [15:0] a_q, b_q, trig_q;

	// working registers
	logic        side_q;
	logic [17:0] cur_q, resl_q, resr_q;
	logic [15:0] fmag_q, tmag_q, z_q, frac_q, fqmag_q;
	logic        fneg_q, tsgn_q, fqneg_q;
	logic [3:0]  p_q, cnt_q;
	logic [19:0] n_q;
	logic [20:0] trx_q;

	// output register
	logic [15:0] ol_q, or_q;
	logic [4:0]  olc_q, orc_q;
	logic        ovalid_q;

	logic        acc;
	div_req_t    dreq;
	div_rsp_t    drsp;

	ddm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// operand conditioning
	logic [16:0] a_mag, b_mag, x_mag, cur_mag, fd_mag, td_mag, ts_mag;
	logic        x_neg, fd_neg;
	logic [15:0] gain;
	logic [14:0] th, turbo_d;
	logic [4:0]  steps_sel;
	logic [17:0] fwd_v;
	logic [19:0] nl, num_mag;
	logic [3:0]  msb;

	always_comb begin
		a_mag     = abs16(a_q);
		b_mag     = abs16(b_q);
		x_mag     = side_q ? b_mag : a_mag;
		x_neg     = side_q ? (b_q[15] ^ rti_q) : (a_q[15] ^ lti_q);
		gain      = turbo_q ? turbo_g_q : normal_g_q;
		cur_mag   = cur_q[17] ? 17'(~cur_q + 18'd1) : cur_q[16:0];
		fd_mag    = (a_mag < DEADBAND) ? 17'd0 : a_mag;
		fd_neg    = a_q[15] && (fd_mag != 17'd0);
		td_mag    = (b_mag < DEADBAND) ? 17'd0 : b_mag;
		ts_mag    = slow_q ? (td_mag >> 1) : td_mag;
		th        = {1'b0, trig_q[14:1]};
		turbo_d   = (!trig_q[15] && ({2'b0, th} >= DEADBAND)) ? th : 15'd0;
		steps_sel = side_q ? rsteps_q : lsteps_q;
		fwd_v     = fneg_q ? 18'(~{2'b00, fmag_q} + 18'd1) : {2'b00, fmag_q};
		nl        = {4'd15 - p_q, 16'd0} - {4'd0, frac_q};
		num_mag   = (n_q >= 20'd32768) ? (n_q - 20'd32768) : (20'd32768 - n_q);
	end

	// leading one of the turn magnitude
	always_comb begin
		msb = 4'd0;
		for (int i = 0; i < 16; i++)
			if (tmag_q[i])
				msb = 4'(i);
	end

	// shared multiplier operand select
	logic [19:0] mx;
	logic [19:0] my;
	logic [39:0] mul_p;

	always_comb begin
		mx = '0;
		my = '0;
		unique case (state_q)
			ST_T_MUL: begin
				mx = 20'(x_mag);
				my = 20'(gain);
			end
			ST_TR_MUL: begin
				mx = 20'(cur_mag);
				my = 20'(TRIM_MAX - steps_sel);
			end
			// divide by 20 as a shift by 2 and a reciprocal of 5
			ST_TR_WAIT: begin
				mx = 20'(trx_q[20:2]);
				my = RCP_DIV5;
			end
			ST_A_FWD: begin
				mx = 20'(fd_mag);
				my = 20'(HALF_Q15) + 20'(turbo_d);
			end
			ST_A_SQ: begin
				mx = 20'(z_q);
				my = 20'(z_q);
			end
			ST_A_LN: begin
				mx = nl;
				my = 20'(LN2_Q16);
			end
			ST_A_MIX: begin
				mx = 20'(fmag_q);
				my = 20'(fqmag_q);
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
		mul_p = 40'(mx) * 40'(my);
	end

	// divider request
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		if (state_q == ST_A_DIV) begin
			dreq.start    = 1'b1;
			dreq.dividend = 36'(num_mag) << 15;
			dreq.divisor  = 21'(n_q) + ONE_Q15;
		end
	end

	// products reduced for the sequencer
	logic [16:0] prod_mag, sq;
	logic [15:0] trq;
	logic [17:0] prod_sgn, mix_v, trim_v;

	always_comb begin
		prod_mag = mul_p[31:15];
		sq       = mul_p[31:15];
		trq      = mul_p[36:21];
		prod_sgn = x_neg ? 18'(~{1'b0, prod_mag} + 18'd1) : {1'b0, prod_mag};
		mix_v    = (fneg_q ^ fqneg_q) ? 18'(~{1'b0, prod_mag} + 18'd1) : {1'b0, prod_mag};
		trim_v   = cur_q[17] ? 18'(~{2'b00, trq} + 18'd1) : {2'b00, trq};
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lti_q      <= 1'b0;
			rti_q      <= 1'b0;
			fwi_q      <= 1'b0;
			tni_q      <= 1'b0;
			turbo_g_q  <= 16'd32768;
			normal_g_q <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LEFT_INV:  lti_q      <= cfg_data[0];
				REG_RIGHT_INV: rti_q      <= cfg_data[0];
				REG_FWD_INV:   fwi_q      <= cfg_data[0];
				REG_TURN_INV:  tni_q      <= cfg_data[0];
				REG_TURBO_G:   turbo_g_q  <= cfg_data;
				REG_NORMAL_G:  normal_g_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// trim step counters, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsteps_q <= '0;
			rsteps_q <= '0;
			latch_q  <= 1'b0;
		end else if (acc) begin
			priority if (s_tdata[49]) begin
				if (!latch_q && rsteps_q < TRIM_MAX)
					rsteps_q <= rsteps_q + 5'd1;
				latch_q <= 1'b1;
			end else if (s_tdata[50]) begin
				if (!latch_q && lsteps_q < TRIM_MAX)
					lsteps_q <= lsteps_q + 5'd1;
				latch_q <= 1'b1;
			end else begin
				latch_q <= 1'b0;
			end
			if (s_tdata[51]) begin
				lsteps_q <= '0;
				rsteps_q <= '0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_tready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:
					if (acc)
						state_q <= s_tuser ? ST_A_FWD : ST_T_MUL;
				ST_T_MUL:   state_q <= ST_T_CHK;
				ST_T_CHK:
					state_q <= ($signed(cur_q) > $signed(TRIM_SPEED)) ? ST_TR_MUL : ST_STORE;
				ST_TR_MUL:  state_q <= ST_TR_WAIT;
				ST_TR_WAIT: state_q <= ST_STORE;
				ST_STORE: begin
					if (side_q)
						state_q <= ST_OUT;
					else
						state_q <= func_q ? ST_TR_MUL : ST_T_MUL;
				end
				ST_A_FWD:   state_q <= ST_A_NORM;
				ST_A_NORM:  state_q <= (tmag_q == 16'd0) ? ST_A_TCHK : ST_A_SQ;
				ST_A_SQ:
					if (cnt_q == 4'd15)
						state_q <= ST_A_LN;
				ST_A_LN:    state_q <= ST_A_DIV;
				ST_A_DIV:   state_q <= ST_A_DWT;
				ST_A_DWT:
					if (drsp.done)
						state_q <= ST_A_MIX;
				ST_A_MIX:   state_q <= ST_A_TCHK;
				ST_A_TCHK:
					state_q <= (!fneg_q && {2'b00, fmag_q} > TRIM_SPEED) ? ST_TR_MUL : ST_OUT;
				ST_OUT:
					if (!ovalid_q || m_tready) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:
				if (acc) begin
					func_q  <= s_tuser;
					a_q     <= s_tdata[15:0];
					b_q     <= s_tdata[31:16];
					trig_q  <= s_tdata[47:32];
					turbo_q <= s_tdata[48];
					slow_q  <= s_tdata[52];
					side_q  <= 1'b0;
				end
			ST_T_MUL:
				cur_q <= prod_sgn;
			ST_TR_MUL:
				trx_q <= mul_p[20:0];
			ST_TR_WAIT:
				cur_q <= trim_v;
			ST_STORE: begin
				if (side_q)
					resr_q <= cur_q;
				else begin
					resl_q <= cur_q;
					side_q <= 1'b1;
					cur_q  <= resr_q;
				end
			end
			ST_A_FWD: begin
				fmag_q <= mul_p[30:15];
				fneg_q <= fd_neg ^ fwi_q;
				tmag_q <= ts_mag[15:0];
				tsgn_q <= b_q[15] ^ fd_neg ^ tni_q;
			end
			ST_A_NORM: begin
				resl_q <= fwd_v;
				resr_q <= fwd_v;
				p_q    <= msb;
				z_q    <= tmag_q << (4'd15 - msb);
				frac_q <= '0;
				cnt_q  <= '0;
			end
			ST_A_SQ: begin
				z_q    <= sq[16] ? sq[16:1] : sq[15:0];
				frac_q <= {frac_q[14:0], sq[16]};
				cnt_q  <= cnt_q + 4'd1;
			end
			ST_A_LN:
				n_q <= 20'((mul_p + 40'd32768) >> 16);
			ST_A_DIV:
				fqneg_q <= (n_q < 20'd32768);
			ST_A_DWT:
				if (drsp.done)
					fqmag_q <= drsp.quot;
			ST_A_MIX: begin
				if (tsgn_q)
					resl_q <= mix_v;
				else
					resr_q <= mix_v;
			end
			ST_A_TCHK: begin
				side_q <= 1'b0;
				cur_q  <= resl_q;
			end
			default: ;
		endcase
	end

	// saturate to Q1.15
	function automatic logic [15:0] sat18(input logic [17:0] v);
		begin
			if ($signed(v) > $signed(18'sd32767))
				sat18 = 16'h7FFF;
			else if ($signed(v) < $signed(-18'sd32768))
				sat18 = 16'h8000;
			else
				sat18 = v[15:0];
		end
	endfunction

	// output register load
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!ovalid_q || m_tready)) begin
			ol_q  <= sat18(resl_q);
			or_q  <= sat18(resr_q);
			olc_q <= lsteps_q;
			orc_q <= rsteps_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {6'd0, orc_q, olc_q, or_q, ol_q};

	// checks
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !s_tready)
		else $error("block still ready after an input transfer");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_A_DWT))
		else $error("divider finished outside a wait state");

	a_trim_limit: assert property (@(posedge clk) disable iff (!arst_n)
		lsteps_q <= TRIM_MAX && rsteps_q <= TRIM_MAX)
		else $error("trim step count above its limit");

	a_trim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tdata[51]) |=> (lsteps_q == 5'd0 && rsteps_q == 5'd0))
		else $error("trim clear did not zero the step counts");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !m_tready) |=> ($stable(ol_q) && $stable(or_q)))
		else $error("pending result overwritten");

endmodule
